/* src/sts_pkg.sv */
// Package for the source token scanner: kinds, error codes, modes, keyword table and character tests.
package sts_pkg;

  localparam int PositionBitsDefault = 16;
  localparam int KeywordMaxLenDefault = 6;
  localparam int KwCount = 18;
  localparam int KwBase = 26;

  localparam logic [5:0] TK_LPAREN = 6'd0;
  localparam logic [5:0] TK_RPAREN = 6'd1;
  localparam logic [5:0] TK_LBRACE = 6'd2;
  localparam logic [5:0] TK_RBRACE = 6'd3;
  localparam logic [5:0] TK_COMMA = 6'd4;
  localparam logic [5:0] TK_DOT = 6'd5;
  localparam logic [5:0] TK_MINUS = 6'd6;
  localparam logic [5:0] TK_PLUS = 6'd7;
  localparam logic [5:0] TK_SEMI = 6'd8;
  localparam logic [5:0] TK_SLASH = 6'd9;
  localparam logic [5:0] TK_STAR = 6'd10;
  localparam logic [5:0] TK_PERCENT = 6'd11;
  localparam logic [5:0] TK_BANG = 6'd12;
  localparam logic [5:0] TK_EQUAL = 6'd14;
  localparam logic [5:0] TK_GREATER = 6'd16;
  localparam logic [5:0] TK_LESS = 6'd18;
  localparam logic [5:0] TK_FSTART = 6'd20;
  localparam logic [5:0] TK_STRING = 6'd21;
  localparam logic [5:0] TK_NUMBER = 6'd22;
  localparam logic [5:0] TK_IDENT = 6'd23;
  localparam logic [5:0] TK_ERROR = 6'd24;
  localparam logic [5:0] TK_END = 6'd25;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CHAR = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;
  localparam logic [1:0] ERR_COMMENT = 2'd3;

  typedef enum logic [10:0] {
    M_IDLE       = 11'b000_0000_0001,
    M_SLASH      = 11'b000_0000_0010,
    M_LINE       = 11'b000_0000_0100,
    M_BLOCK      = 11'b000_0000_1000,
    M_BLOCK_STAR = 11'b000_0001_0000,
    M_OP2        = 11'b000_0010_0000,
    M_STRING     = 11'b000_0100_0000,
    M_NUMBER     = 11'b000_1000_0000,
    M_NUM_DOT    = 11'b001_0000_0000,
    M_FRACTION   = 11'b010_0000_0000,
    M_IDENT      = 11'b100_0000_0000
  } mode_t;

  // keyword text, first char in the low byte, zero padded
  function automatic logic [63:0] kw_text(input int i);
    case (i)
      0: kw_text = 64'h646e61;
      1: kw_text = 64'h6a626f;
      2: kw_text = 64'h65736c65;
      3: kw_text = 64'h65736c6166;
      4: kw_text = 64'h65757274;
      5: kw_text = 64'h726f66;
      6: kw_text = 64'h6e66;
      7: kw_text = 64'h6669;
      8: kw_text = 64'h6f64;
      9: kw_text = 64'h6c696e;
      10: kw_text = 64'h726f;
      11: kw_text = 64'h746e697270;
      12: kw_text = 64'h6e7275746572;
      13: kw_text = 64'h7265707573;
      14: kw_text = 64'h73696874;
      15: kw_text = 64'h726176;
      16: kw_text = 64'h74736e6f63;
      17: kw_text = 64'h656c696877;
      default: kw_text = 64'h0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input int i);
    case (i)
      0, 1, 5, 9, 15: kw_len = 4'd3;
      2, 4, 14: kw_len = 4'd4;
      6, 7, 8, 10: kw_len = 4'd2;
      12: kw_len = 4'd6;
      default: kw_len = 4'd5;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || (b == 8'h5f);
  endfunction

endpackage

/* src/source_token_scanner.sv */
// Source token scanner top level: byte stream in, token stream out.
//
// s_axis carries one source word per beat: tdata[7:0] char_byte, tuser end_of_source.
// A zero byte or end_of_source flushes any pending token and emits an end token.
// m_axis carries one token per word; tlast marks the final token caused by one
// input word. Each input word yields zero to three tokens.
// Tokens of a word appear on m_axis the cycle after it is accepted.
// Throughput: one input word per cycle while each word yields at most one token and
// the receiver is ready; a word yielding more tokens holds the input until the
// three-entry output queue, draining one token per ready cycle, reaches its last token.
// s_axis_tready stays high while the queue is empty or its last token leaves.
// When the receiver stalls, tokens hold in the queue and input is held off.
// Reset (rst, synchronous) empties the queue and returns the scanner to line 1,
// column 1, offset 0, between tokens.
// Blanks and closed comments produce no tokens; newlines inside strings and comments
// still advance the line count.
module source_token_scanner #(
  parameter int PositionBits = sts_pkg::PositionBitsDefault,
  parameter int KeywordMaxLen = sts_pkg::KeywordMaxLenDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // char_byte
  input  logic                          s_axis_tuser,  // end_of_source
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // token_kind, start_offset, lexeme_length, line_number, end_column, error_code
  output logic [((6+4*PositionBits+2+7)/8)*8-1:0] m_axis_tdata,
  output logic                          m_axis_tlast   // last_of_run
);
  localparam int PB = PositionBits;
  localparam int TW = 6 + 4 * PB + 2;
  localparam int DW = ((TW + 7) / 8) * 8;

  logic step;
  logic [1:0] tok_count;
  logic [3*TW-1:0] toks;
  logic [TW-1:0] tok;

  assign step = s_axis_tvalid && s_axis_tready;

  sts_core #(.PositionBits(PB), .KeywordMaxLen(KeywordMaxLen)) u_core (
    .clk(clk), .rst(rst), .step(step),
    .char_byte(s_axis_tdata), .end_of_source(s_axis_tuser),
    .tok_count(tok_count), .toks(toks)
  );

  sts_outq #(.PositionBits(PB)) u_q (
    .clk(clk), .rst(rst), .load(step), .load_count(tok_count), .load_toks(toks),
    .can_load(s_axis_tready), .tvalid(m_axis_tvalid), .tready(m_axis_tready),
    .tok(tok), .tlast(m_axis_tlast)
  );

  // record is {kind, start, len, line, col, err}; tdata has kind lowest
  assign m_axis_tdata = DW'({tok[1:0], tok[2 +: PB], tok[2+PB +: PB], tok[2+2*PB +: PB],
                             tok[2+3*PB +: PB], tok[TW-1 -: 6]});

endmodule

/* src/sts_kwmatch.sv */
// Keyword lookup of a buffered identifier.
module sts_kwmatch #(
  parameter int KeywordMaxLen = sts_pkg::KeywordMaxLenDefault
) (
  input  logic [KeywordMaxLen*8-1:0] text,
  input  logic [3:0]                 len,
  output logic [5:0]                 kind
);
  import sts_pkg::*;

  logic [63:0] wide;
  logic [63:0] mask;

  always_comb begin
    wide = 64'(text);
    kind = TK_IDENT;
    for (int i = KwCount - 1; i >= 0; i--) begin
      mask = (64'd1 << {kw_len(i), 3'd0}) - 64'd1;
      if (kw_len(i) == len && (wide & mask) == kw_text(i)) begin
        kind = 6'(KwBase + i);
      end
    end
  end

endmodule

/* src/sts_core.sv */
// Scanner state and next-state logic: turns one byte into up to three token records.
module sts_core #(
  parameter int PositionBits = sts_pkg::PositionBitsDefault,
  parameter int KeywordMaxLen = sts_pkg::KeywordMaxLenDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [7:0]                  char_byte,
  input  logic                        end_of_source,
  output logic [1:0]                  tok_count,
  output logic [3*(6+4*PositionBits+2)-1:0] toks
);
  import sts_pkg::*;

  localparam int PB = PositionBits;
  localparam int TW = 6 + 4 * PB + 2;
  localparam logic [PB-1:0] PosMax = '1;
  localparam int LW = $clog2(KeywordMaxLen + 2);

  mode_t mode, mode_next;
  logic [PB-1:0] token_start, token_start_next, byte_offset, byte_offset_next;
  logic [PB-1:0] line_count, line_count_next, column_count, column_count_next;
  logic [PB-1:0] tok_len, tok_len_next, dot_start, dot_start_next, dot_col, dot_col_next;
  logic [5:0] op_kind, op_kind_next;
  logic [LW-1:0] ident_length, ident_length_next;
  logic [7:0] ident_buffer [KeywordMaxLen];
  logic buf_we;
  logic [LW-1:0] buf_addr;
  logic [KeywordMaxLen*8-1:0] buf_flat;
  logic [5:0] id_kind;
  logic [TW-1:0] tk [3];
  logic [1:0] cnt;
  logic at_end, reprocess;
  logic [7:0] b;

  function automatic logic [PB-1:0] sinc(input logic [PB-1:0] x);
    sinc = (x == PosMax) ? x : x + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < KeywordMaxLen; i++) buf_flat[i*8 +: 8] = ident_buffer[i];
  end

  sts_kwmatch #(.KeywordMaxLen(KeywordMaxLen)) u_kw (
    .text(buf_flat),
    .len(4'(ident_length)),
    .kind(id_kind)
  );

  always_comb begin
    mode_next = mode;
    token_start_next = token_start;
    byte_offset_next = byte_offset;
    line_count_next = line_count;
    column_count_next = column_count;
    tok_len_next = tok_len;
    dot_start_next = dot_start;
    dot_col_next = dot_col;
    op_kind_next = op_kind;
    ident_length_next = ident_length;
    buf_we = 1'b0;
    buf_addr = '0;
    cnt = 2'd0;
    for (int i = 0; i < 3; i++) tk[i] = '0;
    b = char_byte;
    at_end = end_of_source || (char_byte == 8'h00);
    reprocess = 1'b0;

    // One pass: pending-mode handling, then optional idle handling of the same byte.
    // Emissions use the line count at that moment; position updates happen in order.
    if (at_end) begin
      case (mode)
        M_SLASH: begin
          tk[cnt] = {TK_SLASH, token_start, tok_len, line_count_next, column_count_next, ERR_NONE};
          cnt = cnt + 1'b1;
        end
        M_BLOCK, M_BLOCK_STAR: begin
          tk[cnt] = {TK_ERROR, token_start, tok_len, line_count_next, column_count_next,
                     ERR_COMMENT};
          cnt = cnt + 1'b1;
        end
        M_OP2: begin
          tk[cnt] = {op_kind, token_start, tok_len, line_count_next, column_count_next, ERR_NONE};
          cnt = cnt + 1'b1;
        end
        M_STRING: begin
          tk[cnt] = {TK_STRING, token_start, tok_len, line_count_next, column_count_next,
                     ERR_STRING};
          cnt = cnt + 1'b1;
        end
        M_NUMBER, M_FRACTION: begin
          tk[cnt] = {TK_NUMBER, token_start, tok_len, line_count_next, column_count_next,
                     ERR_NONE};
          cnt = cnt + 1'b1;
        end
        M_NUM_DOT: begin
          tk[0] = {TK_NUMBER, token_start, tok_len, line_count_next, dot_col, ERR_NONE};
          tk[1] = {TK_DOT, dot_start, PB'(1), line_count_next, column_count_next, ERR_NONE};
          cnt = 2'd2;
        end
        M_IDENT: begin
          tk[cnt] = {id_kind, token_start, tok_len, line_count_next, column_count_next, ERR_NONE};
          cnt = cnt + 1'b1;
        end
        default: ;
      endcase
      mode_next = M_IDLE;
      tk[cnt] = {TK_END, byte_offset, PB'(0), line_count_next, column_count_next, ERR_NONE};
      cnt = cnt + 1'b1;
    end else begin
      reprocess = (mode == M_IDLE);
      case (mode)
        M_SLASH: begin
          if (b == 8'h2f || b == 8'h2a) begin
            mode_next = (b == 8'h2f) ? M_LINE : M_BLOCK;
            tok_len_next = sinc(tok_len);
          end else begin
            tk[0] = {TK_SLASH, token_start, tok_len, line_count, column_count, ERR_NONE};
            cnt = 2'd1;
            reprocess = 1'b1;
          end
        end
        M_LINE: if (b == 8'h0a) mode_next = M_IDLE;
        M_BLOCK: begin
          tok_len_next = sinc(tok_len);
          if (b == 8'h2a) mode_next = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          tok_len_next = sinc(tok_len);
          if (b == 8'h2f) mode_next = M_IDLE;
          else if (b != 8'h2a) mode_next = M_BLOCK;
        end
        M_OP2: begin
          if (b == 8'h3d) begin
            mode_next = M_IDLE;
            tok_len_next = sinc(tok_len);
            tk[0] = {op_kind + 6'd1, token_start, sinc(tok_len),
                     (b == 8'h0a) ? sinc(line_count) : line_count, sinc(column_count),
                     ERR_NONE};
            cnt = 2'd1;
          end else begin
            tk[0] = {op_kind, token_start, tok_len, line_count, column_count, ERR_NONE};
            cnt = 2'd1;
            reprocess = 1'b1;
          end
        end
        M_STRING: begin
          if (b == 8'h22) begin
            mode_next = M_IDLE;
            tk[0] = {TK_STRING, token_start, tok_len, line_count, sinc(column_count), ERR_NONE};
            cnt = 2'd1;
          end else begin
            tok_len_next = sinc(tok_len);
          end
        end
        M_NUMBER: begin
          if (is_digit(b)) begin
            tok_len_next = sinc(tok_len);
          end else if (b == 8'h2e) begin
            dot_start_next = byte_offset;
            dot_col_next = column_count;
            mode_next = M_NUM_DOT;
          end else begin
            tk[0] = {TK_NUMBER, token_start, tok_len, line_count, column_count, ERR_NONE};
            cnt = 2'd1;
            reprocess = 1'b1;
          end
        end
        M_NUM_DOT: begin
          if (is_digit(b)) begin
            tok_len_next = sinc(sinc(tok_len));
            mode_next = M_FRACTION;
          end else begin
            tk[0] = {TK_NUMBER, token_start, tok_len, line_count, dot_col, ERR_NONE};
            tk[1] = {TK_DOT, dot_start, PB'(1), line_count, column_count, ERR_NONE};
            cnt = 2'd2;
            reprocess = 1'b1;
          end
        end
        M_FRACTION: begin
          if (is_digit(b)) begin
            tok_len_next = sinc(tok_len);
          end else begin
            tk[0] = {TK_NUMBER, token_start, tok_len, line_count, column_count, ERR_NONE};
            cnt = 2'd1;
            reprocess = 1'b1;
          end
        end
        M_IDENT: begin
          if (b == 8'h22 && ident_length == LW'(1) && ident_buffer[0] == 8'h66) begin
            mode_next = M_IDLE;
            tk[0] = {TK_FSTART, token_start, sinc(tok_len), line_count, sinc(column_count),
                     ERR_NONE};
            cnt = 2'd1;
            tok_len_next = sinc(tok_len);
          end else if (is_letter(b) || is_digit(b)) begin
            tok_len_next = sinc(tok_len);
            if (ident_length < LW'(KeywordMaxLen)) begin
              buf_we = 1'b1;
              buf_addr = ident_length;
            end
            if (ident_length <= LW'(KeywordMaxLen)) ident_length_next = ident_length + 1'b1;
          end else begin
            tk[0] = {id_kind, token_start, tok_len, line_count, column_count, ERR_NONE};
            cnt = 2'd1;
            reprocess = 1'b1;
          end
        end
        default: ;
      endcase

      if (!reprocess) begin
        // byte taken by the pending mode
        byte_offset_next = byte_offset + 1'b1;
        if (b == 8'h0a) begin
          line_count_next = sinc(line_count);
          column_count_next = PB'(1);
        end else begin
          column_count_next = sinc(column_count);
        end
      end else begin
        mode_next = M_IDLE;
        byte_offset_next = byte_offset + 1'b1;
        if (b == 8'h0a) begin
          line_count_next = sinc(line_count);
          column_count_next = PB'(1);
        end else begin
          column_count_next = sinc(column_count);
        end
        if (!(b == 8'h20 || b == 8'h0d || b == 8'h09 || b == 8'h0a)) begin
          if (b == 8'h22) begin
            tok_len_next = '0;
            token_start_next = byte_offset + 1'b1;
            mode_next = M_STRING;
          end else begin
            tok_len_next = PB'(1);
            token_start_next = byte_offset;
            if (b == 8'h2f) mode_next = M_SLASH;
            else if (b == 8'h21) begin op_kind_next = TK_BANG; mode_next = M_OP2; end
            else if (b == 8'h3d) begin op_kind_next = TK_EQUAL; mode_next = M_OP2; end
            else if (b == 8'h3e) begin op_kind_next = TK_GREATER; mode_next = M_OP2; end
            else if (b == 8'h3c) begin op_kind_next = TK_LESS; mode_next = M_OP2; end
            else if (is_digit(b)) mode_next = M_NUMBER;
            else if (is_letter(b)) begin
              buf_we = 1'b1;
              buf_addr = '0;
              ident_length_next = LW'(1);
              mode_next = M_IDENT;
            end else begin
              case (b)
                8'h28: tk[cnt] = {TK_LPAREN, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h29: tk[cnt] = {TK_RPAREN, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h7b: tk[cnt] = {TK_LBRACE, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h7d: tk[cnt] = {TK_RBRACE, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h2c: tk[cnt] = {TK_COMMA, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h2e: tk[cnt] = {TK_DOT, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h2d: tk[cnt] = {TK_MINUS, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h2b: tk[cnt] = {TK_PLUS, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h3b: tk[cnt] = {TK_SEMI, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h2a: tk[cnt] = {TK_STAR, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                8'h25: tk[cnt] = {TK_PERCENT, byte_offset, PB'(1), line_count_next,
                                  column_count_next, ERR_NONE};
                default: tk[cnt] = {TK_ERROR, byte_offset, PB'(1), line_count_next,
                                    column_count_next, ERR_CHAR};
              endcase
              cnt = cnt + 1'b1;
            end
          end
        end
      end
    end
  end

  assign tok_count = cnt;
  assign toks = {tk[2], tk[1], tk[0]};

  always_ff @(posedge clk) begin
    if (step && !at_end && buf_we) ident_buffer[buf_addr[$clog2(KeywordMaxLen)-1:0]] <= b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      token_start <= '0;
      byte_offset <= '0;
      line_count <= PB'(1);
      column_count <= PB'(1);
      tok_len <= '0;
      dot_start <= '0;
      dot_col <= '0;
      op_kind <= '0;
      ident_length <= '0;
    end else if (step) begin
      mode <= mode_next;
      token_start <= token_start_next;
      byte_offset <= byte_offset_next;
      line_count <= line_count_next;
      column_count <= column_count_next;
      tok_len <= tok_len_next;
      dot_start <= dot_start_next;
      dot_col <= dot_col_next;
      op_kind <= op_kind_next;
      ident_length <= ident_length_next;
    end
  end

`ifndef SYNTHESIS
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst) line_count != '0)
    else $error("line count reached zero");
  a_col_nonzero: assert property (@(posedge clk) disable iff (rst) column_count != '0)
    else $error("column count reached zero");
  a_end_tok: assert property (@(posedge clk) disable iff (rst)
    (step && end_of_source) |=> mode == M_IDLE)
    else $error("end marker left a pending mode");
  a_ident_len: assert property (@(posedge clk) disable iff (rst)
    ident_length <= LW'(KeywordMaxLen + 1))
    else $error("identifier length overflow");
`endif

endmodule

/* src/sts_outq.sv */
// Output queue: holds up to three token words of one byte and drains them one per cycle while tready is high.
module sts_outq #(
  parameter int PositionBits = sts_pkg::PositionBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [1:0]                        load_count,
  input  logic [3*(6+4*PositionBits+2)-1:0] load_toks,
  output logic                              can_load,
  output logic                              tvalid,
  input  logic                              tready,
  output logic [6+4*PositionBits+2-1:0]     tok,
  output logic                              tlast
);
  localparam int TW = 6 + 4 * PositionBits + 2;

  logic [TW-1:0] slot [3];
  logic [1:0] count, head;

  assign tvalid = count != 2'd0;
  assign tok = slot[head];
  assign tlast = count == 2'd1;
  // accept a new byte when queue empty or its final word leaves now
  assign can_load = (count == 2'd0) || (count == 2'd1 && tready);

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= load_toks[0 +: TW];
      slot[1] <= load_toks[TW +: TW];
      slot[2] <= load_toks[2*TW +: TW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      head <= 2'd0;
    end else if (load) begin
      count <= load_count;
      head <= 2'd0;
    end else if (tvalid && tready) begin
      count <= count - 1'b1;
      head <= head + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_load_ok: assert property (@(posedge clk) disable iff (rst) load |-> can_load)
    else $error("load into busy queue");
  a_head: assert property (@(posedge clk) disable iff (rst) tvalid |-> head + count <= 2'd3)
    else $error("queue head out of range");
  a_cnt: assert property (@(posedge clk) disable iff (rst) count != 2'd3 || head == 2'd0)
    else $error("full queue with moved head");
`endif

endmodule
